FILE: hdl/wmv_pkg.sv
// types, constants and helper functions shared by the weighted mean and variance core
package wmv_pkg;

    localparam int VALUE_FRAC_BITS  = 16;
    localparam int WEIGHT_FRAC_BITS = 12;
    localparam int RECIP_FRAC_BITS  = 24;

    localparam int VALUE_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int SPREAD_W = 48;
    localparam int TOTAL_W  = 32;
    localparam int HALF_W   = SPREAD_W / 2;
    localparam int PROD_W   = 64;
    localparam int ACC_W    = 128;
    localparam int ROOT_W   = ACC_W / 2;

    localparam int STEPS      = 64;
    localparam int STEP_CNT_W = $clog2(STEPS);
    localparam int SHIFT_W    = 7;

    localparam int ONE_SHIFT = 2 * RECIP_FRAC_BITS + WEIGHT_FRAC_BITS;
    localparam logic [95:0] ONE_VAL = 96'd1 << ONE_SHIFT;

    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_FINALIZE = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_PREP,
        ST_A_MUL,
        ST_A_DIVS,
        ST_A_DIVW,
        ST_A_MEAN,
        ST_A_DIFF,
        ST_A_PROD,
        ST_A_PSAVE,
        ST_MAC,
        ST_A_VDIVS,
        ST_A_VDIVW,
        ST_A_VSAVE,
        ST_F_SQS,
        ST_F_SQW,
        ST_F_EDIVS,
        ST_F_EDIVW,
        ST_F_ESAVE,
        ST_F_RDIVS,
        ST_F_RDIVW,
        ST_F_RSQS,
        ST_F_RSQW,
        ST_F_SAVE,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        MUL_A1W,
        MUL_A1A2,
        MUL_VLO_DW,
        MUL_VHI_DW,
        MUL_PLO_W,
        MUL_PHI_W,
        MUL_V0S0,
        MUL_V0S1,
        MUL_V1S0,
        MUL_V1S1
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_VAR,
        DIV_ERR,
        DIV_RECIP
    } div_src_t;

    typedef enum logic {
        SQ_ACC,
        SQ_QUOT
    } sqrt_src_t;

    typedef struct packed {
        logic      load;
        logic      clear;
        logic      prep;
        logic      mul_en;
        mul_sel_t  mul_sel;
        logic      acc_add;
        logic      div_start;
        div_src_t  div_src;
        logic      mean_upd;
        logic      diff_upd;
        logic      p_load;
        logic      var_save;
        logic      err_save;
        logic      sqrt_start;
        sqrt_src_t sqrt_src;
        logic      fin_save;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic add_ok;
        logic fin_ok;
        logic clr;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } dp_status_t;

    function automatic mul_sel_t mac_step(input logic fin, input logic [1:0] k);
        mul_sel_t s;
        case ({fin, k})
            3'b000:  s = MUL_VLO_DW;
            3'b001:  s = MUL_VHI_DW;
            3'b010:  s = MUL_PLO_W;
            3'b011:  s = MUL_PHI_W;
            3'b100:  s = MUL_V0S0;
            3'b101:  s = MUL_V0S1;
            3'b110:  s = MUL_V1S0;
            3'b111:  s = MUL_V1S1;
            default: s = MUL_A1W;
        endcase
        return s;
    endfunction

    function automatic logic [SHIFT_W-1:0] mac_shift(input mul_sel_t s);
        logic [SHIFT_W-1:0] sh;
        case (s) inside
            MUL_VLO_DW, MUL_V0S0: sh = SHIFT_W'(VALUE_FRAC_BITS);
            MUL_VHI_DW, MUL_V0S1, MUL_V1S0: sh = SHIFT_W'(VALUE_FRAC_BITS + HALF_W);
            MUL_V1S1: sh = SHIFT_W'(VALUE_FRAC_BITS + 2 * HALF_W);
            MUL_PHI_W: sh = SHIFT_W'(PROD_W / 2);
            default: sh = '0;
        endcase
        return sh;
    endfunction

endpackage

FILE: hdl/wmv_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module wmv_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] hi,
    input  logic [63:0] lo,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic        ovf,
    output logic [63:0] quot
);
    import wmv_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [31:0]           rem_reg;
    logic [63:0]           lo_reg;
    logic [31:0]           div_reg;
    logic                  ovf_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    always_comb
    begin
        trial = {rem_reg, lo_reg[63]};
        diff  = trial - {1'b0, div_reg};
        ge    = trial >= {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= hi;
            lo_reg  <= lo;
            div_reg <= divisor;
            ovf_reg <= hi >= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            lo_reg  <= {lo_reg[62:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quot = lo_reg;

endmodule

FILE: hdl/wmv_sqrt.sv
// digit-by-digit integer square root, one root bit per cycle
module wmv_sqrt (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] rad,
    output logic         busy,
    output logic         done,
    output logic [63:0]  root
);
    import wmv_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [127:0]          x_reg;
    logic [65:0]           rem_reg;
    logic [63:0]           root_reg;

    logic [67:0] r4;
    logic [67:0] trial;
    logic [67:0] diff;
    logic        ge;

    always_comb
    begin
        r4    = {rem_reg, x_reg[127:126]};
        trial = {2'b00, root_reg, 2'b01};
        diff  = r4 - trial;
        ge    = r4 >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[125:0], 2'b00};
            rem_reg  <= ge ? diff[65:0] : r4[65:0];
            root_reg <= {root_reg[62:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: hdl/wmv_dpath.sv
// datapath: running statistics, multiplier, accumulator, divider, square root, output register
module wmv_dpath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wmv_pkg::ctrl_cmd_t     cmd,
    output wmv_pkg::dp_status_t    status,
    input  logic [1:0]             command,
    input  logic signed [31:0]     sample_value,
    input  logic [15:0]            sample_weight,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic signed [31:0]     mean_out,
    output logic [47:0]            spread_out,
    output logic [31:0]            weight_out,
    output logic [47:0]            square_out,
    output logic                   finished_out
);
    import wmv_pkg::*;

    logic signed [VALUE_W-1:0] mean_reg;
    logic [SPREAD_W-1:0]       var_reg;
    logic [TOTAL_W-1:0]        wtot_reg;
    logic [SPREAD_W-1:0]       sq_reg;
    logic                      fin_reg;

    logic signed [VALUE_W-1:0] x_reg;
    logic [WEIGHT_W-1:0]       w_reg;
    logic [31:0]               a1_reg;
    logic                      neg_reg;
    logic [31:0]               a2_reg;
    logic [31:0]               dw_reg;
    logic [PROD_W-1:0]         p_reg;
    logic [PROD_W-1:0]         prod_reg;
    mul_sel_t                  prod_sel_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [SPREAD_W-1:0]       err_reg;

    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] mean_out_reg;
    logic [SPREAD_W-1:0]       spread_out_reg;
    logic [TOTAL_W-1:0]        weight_out_reg;
    logic [SPREAD_W-1:0]       square_out_reg;
    logic                      finished_out_reg;

    logic [32:0]         diff;
    logic [32:0]         diff_abs;
    logic [32:0]         wsum;
    logic [TOTAL_W-1:0]  wnew;
    logic [31:0]         wsq;
    logic [48:0]         ssum;
    logic [SPREAD_W-1:0] snew;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [31:0]         div_hi;
    logic [63:0]         div_lo;
    logic                div_busy;
    logic                div_done;
    logic                div_ovf;
    logic [63:0]         div_quot;
    logic [SPREAD_W-1:0] quot_sat;
    logic [127:0]        sqrt_rad;
    logic                sqrt_busy;
    logic                sqrt_done;
    logic [ROOT_W-1:0]   sqrt_root;

    always_comb
    begin
        diff     = {x_reg[VALUE_W-1], x_reg} - {mean_reg[VALUE_W-1], mean_reg};
        diff_abs = diff[32] ? (33'd0 - diff) : diff;
        wsum     = {1'b0, wtot_reg} + 33'(w_reg);
        wnew     = wsum[32] ? '1 : wsum[31:0];
        wsq      = w_reg * w_reg;
        ssum     = {1'b0, sq_reg} + 49'(wsq);
        snew     = ssum[48] ? '1 : ssum[47:0];
        quot_sat = (div_ovf || (|div_quot[63:SPREAD_W])) ? '1 : div_quot[SPREAD_W-1:0];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_A1W:
            begin
                mul_a = a1_reg;
                mul_b = 32'(w_reg);
            end
            MUL_A1A2:
            begin
                mul_a = a1_reg;
                mul_b = a2_reg;
            end
            MUL_VLO_DW:
            begin
                mul_a = 32'(var_reg[HALF_W-1:0]);
                mul_b = dw_reg;
            end
            MUL_VHI_DW:
            begin
                mul_a = 32'(var_reg[SPREAD_W-1:HALF_W]);
                mul_b = dw_reg;
            end
            MUL_PLO_W:
            begin
                mul_a = p_reg[31:0];
                mul_b = 32'(w_reg);
            end
            MUL_PHI_W:
            begin
                mul_a = p_reg[63:32];
                mul_b = 32'(w_reg);
            end
            MUL_V0S0:
            begin
                mul_a = 32'(var_reg[HALF_W-1:0]);
                mul_b = 32'(sq_reg[HALF_W-1:0]);
            end
            MUL_V0S1:
            begin
                mul_a = 32'(var_reg[HALF_W-1:0]);
                mul_b = 32'(sq_reg[SPREAD_W-1:HALF_W]);
            end
            MUL_V1S0:
            begin
                mul_a = 32'(var_reg[SPREAD_W-1:HALF_W]);
                mul_b = 32'(sq_reg[HALF_W-1:0]);
            end
            MUL_V1S1:
            begin
                mul_a = 32'(var_reg[SPREAD_W-1:HALF_W]);
                mul_b = 32'(sq_reg[SPREAD_W-1:HALF_W]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        div_hi = '0;
        div_lo = '0;
        case (cmd.div_src)
            DIV_MEAN:  div_lo = prod_reg;
            DIV_VAR:
            begin
                div_hi = acc_reg[VALUE_FRAC_BITS+64 +: 32];
                div_lo = acc_reg[VALUE_FRAC_BITS +: 64];
            end
            DIV_ERR:   div_lo = sqrt_root;
            DIV_RECIP:
            begin
                div_hi = ONE_VAL[95:64];
                div_lo = ONE_VAL[63:0];
            end
            default:
            begin
                div_hi = '0;
                div_lo = '0;
            end
        endcase
        sqrt_rad = (cmd.sqrt_src == SQ_QUOT) ? {64'd0, div_quot} : acc_reg;
    end

    wmv_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .hi      (div_hi),
        .lo      (div_lo),
        .divisor (wtot_reg),
        .busy    (div_busy),
        .done    (div_done),
        .ovf     (div_ovf),
        .quot    (div_quot)
    );

    wmv_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .rad   (sqrt_rad),
        .busy  (sqrt_busy),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // running statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            var_reg  <= '0;
            wtot_reg <= '0;
            sq_reg   <= '0;
            fin_reg  <= 1'b0;
        end
        else if (cmd.clear)
        begin
            mean_reg <= '0;
            var_reg  <= '0;
            wtot_reg <= '0;
            sq_reg   <= '0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.prep)
            begin
                wtot_reg <= wnew;
                sq_reg   <= snew;
            end
            if (cmd.mean_upd)
            begin
                mean_reg <= neg_reg ? (mean_reg - $signed(div_quot[31:0]))
                                    : (mean_reg + $signed(div_quot[31:0]));
            end
            if (cmd.var_save)
            begin
                var_reg <= quot_sat;
            end
            if (cmd.fin_save)
            begin
                var_reg  <= err_reg;
                wtot_reg <= (|sqrt_root[63:32]) ? '1 : sqrt_root[31:0];
                sq_reg   <= var_reg;
                fin_reg  <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= sample_value;
            w_reg   <= sample_weight;
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + (ACC_W'(prod_reg) << mac_shift(prod_sel_reg));
        end
        if (cmd.prep)
        begin
            a1_reg  <= diff_abs[31:0];
            neg_reg <= diff[32];
        end
        if (cmd.diff_upd)
        begin
            a2_reg <= diff_abs[31:0];
            dw_reg <= wtot_reg - 32'(w_reg);
        end
        if (cmd.mul_en)
        begin
            prod_reg     <= mul_p;
            prod_sel_reg <= cmd.mul_sel;
        end
        if (cmd.p_load)
        begin
            p_reg <= prod_reg;
        end
        if (cmd.err_save)
        begin
            err_reg <= quot_sat;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            mean_out_reg     <= mean_reg;
            spread_out_reg   <= var_reg;
            weight_out_reg   <= wtot_reg;
            square_out_reg   <= sq_reg;
            finished_out_reg <= fin_reg;
        end
    end

    always_comb
    begin
        status.add_ok    = (command == CMD_ADD) && !fin_reg && (sample_weight != '0);
        status.fin_ok    = (command == CMD_FINALIZE) && !fin_reg && (wtot_reg != '0);
        status.clr       = command == CMD_CLEAR;
        status.div_done  = div_done;
        status.sqrt_done = sqrt_done;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign mean_out     = mean_out_reg;
    assign spread_out   = spread_out_reg;
    assign weight_out   = weight_out_reg;
    assign square_out   = square_out_reg;
    assign finished_out = finished_out_reg;

    a_div_idle : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_sqrt_idle : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start |-> !sqrt_busy)
        else $error("square root started while busy");

    a_out_slot : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result overwritten before transfer");

    a_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (!fin_reg && wtot_reg == '0) |-> (mean_reg == '0 && var_reg == '0 && sq_reg == '0))
        else $error("statistics nonzero with empty weight sum");

    a_fin_weight : assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> (wtot_reg != '0))
        else $error("finalized with zero reciprocal root");

endmodule

FILE: hdl/wmv_ctrl.sv
// controller state machine sequencing add, finalize, clear and no-op items
module wmv_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  wmv_pkg::dp_status_t status,
    output wmv_pkg::ctrl_cmd_t  cmd
);
    import wmv_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] mac_cnt_reg;
    logic [2:0] mac_cnt_next;
    logic       fin_op_reg;
    logic       fin_op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mac_cnt_reg <= '0;
            fin_op_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mac_cnt_reg <= mac_cnt_next;
            fin_op_reg  <= fin_op_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mac_cnt_next = mac_cnt_reg;
        fin_op_next  = fin_op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                mac_cnt_next = '0;
                if (in_valid)
                begin
                    fin_op_next = status.fin_ok;
                    if (status.add_ok)
                        state_next = ST_A_PREP;
                    else if (status.fin_ok)
                        state_next = ST_MAC;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_A_PREP:  state_next = ST_A_MUL;
            ST_A_MUL:   state_next = ST_A_DIVS;
            ST_A_DIVS:  state_next = ST_A_DIVW;
            ST_A_DIVW:  if (status.div_done) state_next = ST_A_MEAN;
            ST_A_MEAN:  state_next = ST_A_DIFF;
            ST_A_DIFF:  state_next = ST_A_PROD;
            ST_A_PROD:  state_next = ST_A_PSAVE;
            ST_A_PSAVE: state_next = ST_MAC;
            ST_MAC:
            begin
                mac_cnt_next = mac_cnt_reg + 3'd1;
                if (mac_cnt_reg[2])
                    state_next = fin_op_reg ? ST_F_SQS : ST_A_VDIVS;
            end
            ST_A_VDIVS: state_next = ST_A_VDIVW;
            ST_A_VDIVW: if (status.div_done) state_next = ST_A_VSAVE;
            ST_A_VSAVE: state_next = ST_OUT;
            ST_F_SQS:   state_next = ST_F_SQW;
            ST_F_SQW:   if (status.sqrt_done) state_next = ST_F_EDIVS;
            ST_F_EDIVS: state_next = ST_F_EDIVW;
            ST_F_EDIVW: if (status.div_done) state_next = ST_F_ESAVE;
            ST_F_ESAVE: state_next = ST_F_RDIVS;
            ST_F_RDIVS: state_next = ST_F_RDIVW;
            ST_F_RDIVW: if (status.div_done) state_next = ST_F_RSQS;
            ST_F_RSQS:  state_next = ST_F_RSQW;
            ST_F_RSQW:  if (status.sqrt_done) state_next = ST_F_SAVE;
            ST_F_SAVE:  state_next = ST_OUT;
            ST_OUT:     if (status.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = MUL_A1W;
        cmd.div_src  = DIV_MEAN;
        cmd.sqrt_src = SQ_ACC;
        in_stall     = state_reg != ST_IDLE;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load  = in_valid;
                cmd.clear = in_valid && status.clr;
            end
            ST_A_PREP: cmd.prep = 1'b1;
            ST_A_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_A1W;
            end
            ST_A_DIVS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DIV_MEAN;
            end
            ST_A_MEAN: cmd.mean_upd = 1'b1;
            ST_A_DIFF: cmd.diff_upd = 1'b1;
            ST_A_PROD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_A1A2;
            end
            ST_A_PSAVE: cmd.p_load = 1'b1;
            ST_MAC:
            begin
                cmd.mul_en  = !mac_cnt_reg[2];
                cmd.mul_sel = mac_step(fin_op_reg, mac_cnt_reg[1:0]);
                cmd.acc_add = mac_cnt_reg != '0;
            end
            ST_A_VDIVS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DIV_VAR;
            end
            ST_A_VSAVE: cmd.var_save = 1'b1;
            ST_F_SQS:
            begin
                cmd.sqrt_start = 1'b1;
                cmd.sqrt_src   = SQ_ACC;
            end
            ST_F_EDIVS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DIV_ERR;
            end
            ST_F_ESAVE: cmd.err_save = 1'b1;
            ST_F_RDIVS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DIV_RECIP;
            end
            ST_F_RSQS:
            begin
                cmd.sqrt_start = 1'b1;
                cmd.sqrt_src   = SQ_QUOT;
            end
            ST_F_SAVE: cmd.fin_save = 1'b1;
            ST_OUT:    cmd.out_load = status.out_free;
            default:   cmd.load = 1'b0;
        endcase
    end

endmodule

FILE: hdl/weighted_mean_variance_core.sv
// top level of the weighted running mean and variance core
//
//  channel  signals                                        direction
//  in       in_valid, in_stall, command, sample_value,     into core
//           sample_weight
//  out      out_valid, out_stall, mean_out, spread_out,     out of core
//           weight_out, square_out, finished_out
//
// one item at a time; adds use the 64-step radix-2 divider, finalizes
// also the 64-step square-root unit; every item, clear, no-op and
// ignored ones too, may also wait on out_stall
// rst_n clears the statistics and all control state at once
// a finished result waits in the output register while the next item is taken
module weighted_mean_variance_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic signed [31:0] sample_value,
    input  logic [15:0]        sample_weight,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] mean_out,
    output logic [47:0]        spread_out,
    output logic [31:0]        weight_out,
    output logic [47:0]        square_out,
    output logic               finished_out
);
    import wmv_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    wmv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    wmv_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .command       (command),
        .sample_value  (sample_value),
        .sample_weight (sample_weight),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .mean_out      (mean_out),
        .spread_out    (spread_out),
        .weight_out    (weight_out),
        .square_out    (square_out),
        .finished_out  (finished_out)
    );

endmodule

FILE: bench/tb.sv
// testbench for the weighted running mean and variance core
module tb;
    import wmv_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] mean;
        logic [47:0] spread;
        logic [31:0] weight;
        logic [47:0] square;
        logic        finished;
    } stats_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         command = CMD_NOP;
    logic signed [31:0] sample_value = '0;
    logic [15:0]        sample_weight = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] mean_out;
    logic [47:0]        spread_out;
    logic [31:0]        weight_out;
    logic [47:0]        square_out;
    logic               finished_out;

    stats_t stats_model;
    stats_t expected_stats[$];
    int     errors = 0;
    int     idle_cycles = 0;
    int     burst_left = 0;
    int     stall_mode = 0;
    int     stall_left = 0;

    weighted_mean_variance_core u_top (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] isqrt(input logic [127:0] x);
        logic [63:0]  res;
        logic [63:0]  t;
        logic [127:0] sq;
        res = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = res | (64'd1 << b);
            sq = {64'd0, t} * {64'd0, t};
            if (sq <= x)
                res = t;
        end
        return res;
    endfunction

    function automatic void add_sample(input logic [31:0] raw, input logic [15:0] w);
        longint       x;
        longint       m_old;
        longint       m_new;
        longint       delta;
        logic [63:0]  wnew;
        logic [63:0]  s_new;
        logic [63:0]  a1;
        logic [63:0]  a2;
        logic [63:0]  p;
        logic [127:0] num;
        logic [127:0] q;
        x = longint'($signed(raw));
        wnew = {32'd0, stats_model.weight} + w;
        if (wnew > 64'hFFFF_FFFF)
            wnew = 64'hFFFF_FFFF;
        s_new = {16'd0, stats_model.square} + w * w;
        if (s_new > 64'hFFFF_FFFF_FFFF)
            s_new = 64'hFFFF_FFFF_FFFF;
        m_old = longint'($signed(stats_model.mean));
        delta = x - m_old;
        m_new = m_old + (delta * longint'(w)) / longint'(wnew);
        a1 = (delta < 0) ? -delta : delta;
        delta = x - m_new;
        a2 = (delta < 0) ? -delta : delta;
        p = a1 * a2;
        num = (({80'd0, stats_model.spread} * {64'd0, wnew - w}) << VALUE_FRAC_BITS)
            + {64'd0, p} * {112'd0, w};
        q = num / {48'd0, wnew, 16'd0};
        stats_model.mean = m_new[31:0];
        stats_model.weight = wnew[31:0];
        stats_model.square = s_new[47:0];
        stats_model.spread = (q > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : q[47:0];
    endfunction

    function automatic void finalize_stats();
        logic [63:0]  err;
        logic [63:0]  recip;
        logic [127:0] prod;
        prod = ({80'd0, stats_model.spread} * {80'd0, stats_model.square}) << VALUE_FRAC_BITS;
        err = isqrt(prod) / stats_model.weight;
        recip = isqrt((128'd1 << ONE_SHIFT) / stats_model.weight);
        stats_model.square = stats_model.spread;
        stats_model.spread = (err > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : err[47:0];
        stats_model.weight = (recip > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : recip[31:0];
        stats_model.finished = 1'b1;
    endfunction

    function automatic void predict_item(input logic [1:0] cmd, input logic [31:0] x,
                                         input logic [15:0] w);
        case (cmd)
            CMD_ADD:
                if (!stats_model.finished && w != 0)
                    add_sample(x, w);
            CMD_FINALIZE:
                if (!stats_model.finished && stats_model.weight != 0)
                    finalize_stats();
            CMD_CLEAR:
                stats_model = '0;
            default: ;
        endcase
        expected_stats.insert(expected_stats.size(), stats_model);
    endfunction

    // predict on input transfer, compare on output transfer
    always @(posedge clk)
    begin
        stats_t exp_s;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_item(command, sample_value, sample_weight);
            if (out_valid && !out_stall)
            begin
                if (expected_stats.size() == 0)
                begin
                    $display("%0t: unexpected result mean=%h", $time, mean_out);
                    errors++;
                end
                else
                begin
                    exp_s = expected_stats.pop_front();
                    if (mean_out !== exp_s.mean)
                    begin
                        $display("%0t: mean exp %h got %h", $time, exp_s.mean, mean_out);
                        errors++;
                    end
                    if (spread_out !== exp_s.spread)
                    begin
                        $display("%0t: spread exp %h got %h", $time, exp_s.spread,
                                 spread_out);
                        errors++;
                    end
                    if (weight_out !== exp_s.weight)
                    begin
                        $display("%0t: weight exp %h got %h", $time, exp_s.weight,
                                 weight_out);
                        errors++;
                    end
                    if (square_out !== exp_s.square)
                    begin
                        $display("%0t: square exp %h got %h", $time, exp_s.square,
                                 square_out);
                        errors++;
                    end
                    if (finished_out !== exp_s.finished)
                    begin
                        $display("%0t: finished exp %b got %b", $time, exp_s.finished,
                                 finished_out);
                        errors++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 400);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= ($urandom_range(0, 9) != 0);
            default: out_stall <= ($urandom_range(0, 99) < 50);
        endcase
    end

    task automatic send_item(input logic [1:0] cmd, input logic [31:0] x,
                             input logic [15:0] w);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        command <= cmd;
        sample_value <= x;
        sample_weight <= w;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 16'(16'hFFFF - $urandom_range(0, 255));
            1: return 16'($urandom_range(1, 16));
            2: return 16'd0;
            default: return 16'($urandom_range(1, 16'hFFFF));
        endcase
    endfunction

    task automatic test_edge_cases();
        send_item(CMD_FINALIZE, 32'd0, 16'd0);
        send_item(CMD_ADD, 32'h1234_5678, 16'd0);
        send_item(CMD_NOP, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_ADD, 32'h7FFF_FFFF, 16'hFFFF);
        send_item(CMD_ADD, 32'h8000_0000, 16'hFFFF);
        send_item(CMD_ADD, 32'h7FFF_FFFF, 16'd1);
        send_item(CMD_ADD, 32'h8000_0000, 16'd1);
        send_item(CMD_ADD, 32'h0000_0000, 16'h1000);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 16'h8000);
        send_item(CMD_FINALIZE, 32'd0, 16'd0);
        send_item(CMD_ADD, 32'h0001_0000, 16'h1000);
        send_item(CMD_FINALIZE, 32'd0, 16'd0);
        send_item(CMD_NOP, 32'd0, 16'd0);
        send_item(CMD_CLEAR, 32'hAAAA_5555, 16'h5AA5);
        send_item(CMD_ADD, 32'h0001_0000, 16'd1);
        send_item(CMD_FINALIZE, 32'd0, 16'd0);
        send_item(CMD_CLEAR, 32'd0, 16'd0);
        send_item(CMD_ADD, 32'h8000_0000, 16'hFFFF);
        send_item(CMD_ADD, 32'h8000_0000, 16'hFFFF);
        send_item(CMD_FINALIZE, 32'd0, 16'd0);
        send_item(CMD_CLEAR, 32'd0, 16'd0);
    endtask

    task automatic test_random_runs(input int n_items);
        int sent;
        int run_len;
        int n_extra;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                send_item(2'($urandom_range(0, 3)), $urandom(), 16'($urandom()));
                sent++;
            end
            else
            begin
                send_item(CMD_CLEAR, $urandom(), 16'($urandom()));
                run_len = $urandom_range(1, 25);
                repeat (run_len)
                    send_item(($urandom_range(0, 15) == 0) ? CMD_NOP : CMD_ADD,
                              rand_value(), rand_weight());
                send_item(CMD_FINALIZE, $urandom(), 16'($urandom()));
                n_extra = $urandom_range(0, 2);
                repeat (n_extra)
                    send_item($urandom_range(0, 3) == 2 ? CMD_FINALIZE : CMD_ADD,
                              rand_value(), rand_weight());
                sent += run_len + 2 + n_extra;
            end
        end
    endtask

    initial
    begin
        stats_model = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        test_edge_cases();
        test_random_runs(1130);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
